/* rtl/sird_pkg.sv */
package sird_pkg;

  // Radix limits and digit buffer depth
  localparam int unsigned MaxRadix  = 16;
  localparam int unsigned MaxDigits = 32;
  localparam int unsigned MinRadix  = 2;

  localparam int unsigned RadixW = $clog2(MaxRadix + 1);     // base_len width
  localparam int unsigned DigitW = $clog2(MaxRadix);         // one digit / alphabet index
  localparam int unsigned BufAw  = $clog2(MaxDigits);        // digit buffer address
  localparam int unsigned CntW   = $clog2(MaxDigits + 1);    // digit count

  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 8;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 2;

  // Bits of the magnitude consumed per divider cycle
  localparam int unsigned BitsPerStep = 8;
  localparam int unsigned StepsPerDigit = ValueW / BitsPerStep;
  localparam int unsigned StepW = $clog2(StepsPerDigit);

  // Character codes
  localparam logic [CharW-1:0] ChLow   = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChHigh  = 8'h7A;  // 'z'
  localparam logic [CharW-1:0] ChMinus = 8'h2D;  // '-'

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBaseLen    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDigitsLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDigitsHigh = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture a new item
    logic div_step;    // one divider cycle
    logic emit_sign;   // put out the minus sign
    logic emit_digit;  // put out the next stored digit
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cfg_ok;      // radix and alphabet are usable
    logic neg;         // current item is negative
    logic div_done;    // this divider cycle ends the last digit
    logic cnt_one;     // one digit left to emit
  } sts_t;

endpackage

/* rtl/sird_ctrl.sv */
module sird_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output sird_pkg::cmd_t cmd_o,
  input  sird_pkg::sts_t sts_i
);
  import sird_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        // an item with unusable configuration produces nothing
        if (start_i && sts_i.cfg_ok) begin
          cmd_o.load = 1'b1;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = sts_i.neg ? StSign : StEmit;
        end
      end
      StSign: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = StEmit;
      end
      StEmit: begin
        cmd_o.emit_digit = 1'b1;
        if (sts_i.cnt_one) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule

/* rtl/sird_dp.sv */
module sird_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [sird_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sird_pkg::CfgW-1:0]      cfg_data_i,
  input  logic [sird_pkg::ValueW-1:0]    value_i,
  input  sird_pkg::cmd_t                 cmd_i,
  output sird_pkg::sts_t                 sts_o,
  output logic                           out_strobe_o,
  output logic [sird_pkg::CharW-1:0]     out_char_o,
  output logic                           last_o
);
  import sird_pkg::*;

  // Configuration registers
  logic [RadixW-1:0] base_len_q;
  logic [CfgW-1:0]   digits_low_q, digits_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_len_q    <= '0;
      digits_low_q  <= '0;
      digits_high_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBaseLen:    base_len_q    <= cfg_data_i[RadixW-1:0];
        RegDigitsLow:  digits_low_q  <= cfg_data_i;
        RegDigitsHigh: digits_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [2*CfgW-1:0] alphabet;
  assign alphabet = {digits_high_q, digits_low_q};

  // Radix range and alphabet character check
  logic cfg_ok;
  always_comb begin
    logic [CharW-1:0] c;
    cfg_ok = (base_len_q >= RadixW'(MinRadix)) && (base_len_q <= RadixW'(MaxRadix));
    for (int i = 0; i < MaxRadix; i++) begin
      c = alphabet[i*CharW +: CharW];
      if ((RadixW'(i) < base_len_q) && ((c < ChLow) || (c > ChHigh))) begin
        cfg_ok = 1'b0;
      end
    end
  end

  // Divider state: remaining bits of the dividend, partial quotient, remainder
  logic [ValueW-1:0] mag_q, quo_q;
  logic [DigitW-1:0] rem_q;
  logic [StepW-1:0]  step_q;
  logic              neg_q;
  logic [CntW-1:0]   cnt_q;
  logic [DigitW-1:0] buf_q [MaxDigits];

  // Radix-2 restoring steps over one byte of the dividend
  logic [DigitW-1:0]      rem_next;
  logic [BitsPerStep-1:0] qbits;
  always_comb begin
    logic [DigitW:0] r;
    rem_next = rem_q;
    qbits    = '0;
    for (int k = 0; k < BitsPerStep; k++) begin
      r = {rem_next, mag_q[ValueW-1-k]};
      if (r >= (DigitW+1)'(base_len_q)) begin
        r = r - (DigitW+1)'(base_len_q);
        qbits[BitsPerStep-1-k] = 1'b1;
      end
      rem_next = r[DigitW-1:0];
    end
  end

  logic [ValueW-1:0] quo_full;
  logic              last_step;
  assign quo_full  = {quo_q[ValueW-BitsPerStep-1:0], qbits};
  assign last_step = (step_q == StepW'(StepsPerDigit - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
    end else if (cmd_i.load) begin
      step_q <= '0;
      cnt_q  <= '0;
      neg_q  <= value_i[ValueW-1];
    end else if (cmd_i.div_step) begin
      step_q <= step_q + StepW'(1);
      if (last_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end else if (cmd_i.emit_digit) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (last_step) begin
        mag_q <= quo_full;
        rem_q <= '0;
        buf_q[cnt_q[BufAw-1:0]] <= rem_next;
      end else begin
        mag_q <= mag_q << BitsPerStep;
        rem_q <= rem_next;
        quo_q <= quo_full;
      end
    end
  end

  // Digits come out most significant first
  logic [BufAw-1:0]  rd_idx;
  logic [DigitW-1:0] rd_digit;
  assign rd_idx   = cnt_q[BufAw-1:0] - BufAw'(1);
  assign rd_digit = buf_q[rd_idx];

  assign sts_o.cfg_ok   = cfg_ok;
  assign sts_o.neg      = neg_q;
  assign sts_o.div_done = last_step &&
                          ((quo_full == '0) || (cnt_q == CntW'(MaxDigits - 1)));
  assign sts_o.cnt_one  = (cnt_q == CntW'(1));

  // Output register
  logic             strobe_q;
  logic [CharW-1:0] char_q;
  logic             last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_sign || cmd_i.emit_digit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= ChMinus;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= alphabet[rd_digit*CharW +: CharW];
      last_q <= (cnt_q == CntW'(1));
    end
  end

  assign out_strobe_o = strobe_q;
  assign out_char_o   = char_q;
  assign last_o       = strobe_q && last_q;

endmodule

/* rtl/signed_int_to_radix_digits.sv */
// Channel   Handshake                    Payload
// input     start_i high, busy_o low     value_i
// result    out_strobe_o (one cycle)     out_char_o, last_o
// config    cfg_valid_i && cfg_ready_o   cfg_index_i, cfg_data_i
//
// An item holds busy_o while it is divided into digits, while a minus sign is put
// out for a negative value and while its digits are emitted: the shared divider
// retires 8 dividend bits per cycle, then the stored digits leave one per cycle
// through the output register, the last one in the first cycle with busy_o low.
// Async active-low reset clears control and config; no clearing pass.
// Results cannot be stalled; cfg_ready_o is always high.
module signed_int_to_radix_digits (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [sird_pkg::ValueW-1:0]  value_i,
  output logic                         out_strobe_o,
  output logic [sird_pkg::CharW-1:0]   out_char_o,
  output logic                         last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sird_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sird_pkg::CfgW-1:0]    cfg_data_i
);
  import sird_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  sird_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  sird_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_strobe_o (out_strobe_o),
    .out_char_o   (out_char_o),
    .last_o       (last_o)
  );

endmodule

/* rtl/sird_chk.sv */
module sird_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic busy_o,
  input logic out_strobe_o,
  input logic last_o
);

  // a character only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(busy_o))
    else $error("result strobe without preceding busy cycle");

  // the characters of one number come back to back
  a_chars_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_o) |=> out_strobe_o)
    else $error("gap inside a number's characters");

  // nothing follows the last character right away
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && last_o) |=> !out_strobe_o)
    else $error("strobe directly after last character");

  // end of busy is marked by the last character
  a_busy_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (out_strobe_o && last_o))
    else $error("busy ended without last character");

endmodule

bind signed_int_to_radix_digits sird_chk u_sird_chk (.*);
